// ===== hdl/rtcp_pkg.sv =====
// ----------------------------------------------------------------------------
// rtcp_pkg
// shared constants and types of the receiver report block generator
// ----------------------------------------------------------------------------
package rtcp_pkg;

	localparam int SNAP_ENTRIES = 64;
	localparam int SNAP_AW      = (SNAP_ENTRIES > 1) ? $clog2(SNAP_ENTRIES) : 1;
	localparam int SNAP_W       = 96;

	localparam int DVD_W = 42;
	localparam int DSR_W = 33;
	localparam int DIV_CW = $clog2(DVD_W + 1);

	localparam int IN_DATA_W  = 288;
	localparam int IN_USER_W  = 3;
	localparam int OUT_DATA_W = 200;
	localparam int CFG_W      = 16;

	localparam logic [0:0] REG_INTERVAL = 1'b0;
	localparam logic [0:0] REG_MAX      = 1'b1;

	localparam logic OP_SENDER = 1'b0;

	localparam logic [63:0] DELAY_SAT_MS = 64'd65536000;
	// ceil(2^33 / 125), exact quotient by 125 for 26 bit numerators
	localparam logic [26:0] DIV125_M     = 27'd68719477;
	// ceil(2^27 / 125), exact for numerators below 2^20
	localparam logic [20:0] FRAC125_M    = 21'd1073742;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DLY,
		ST_DLYW,
		ST_DLYF,
		ST_SCAN,
		ST_FRAC1,
		ST_FRAC2,
		ST_FRACW,
		ST_WRITE
	} state_t;

endpackage

// ===== hdl/rtcp_ram.sv =====
// ----------------------------------------------------------------------------
// rtcp_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module rtcp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/rtcp_div.sv =====
// ----------------------------------------------------------------------------
// rtcp_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rtcp_div
	import rtcp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DSR_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	logic [DSR_W-1:0]  rem_q;
	logic [DVD_W-1:0]  quo_q;
	logic [DSR_W-1:0]  dsr_q;
	logic [DIV_CW-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DSR_W:0]    shifted;
	logic [DSR_W+1:0]  trial;

	assign shifted  = {rem_q, quo_q[DVD_W-1]};
	assign trial    = {1'b0, shifted} - {2'b00, dsr_q};
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CW'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!trial[DSR_W+1]) begin
				rem_q <= trial[DSR_W-1:0];
				quo_q <= {quo_q[DVD_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DSR_W-1:0];
				quo_q <= {quo_q[DVD_W-2:0], 1'b0};
			end
		end
	end

endmodule

// ===== hdl/rtcp_report_block_generator.sv =====
// ----------------------------------------------------------------------------
// rtcp_report_block_generator
// rtcp receiver report blocks from sender arrivals and source statistics
// ----------------------------------------------------------------------------
// A sender report is taken without leaving the idle state. A block request walks
// the whole snapshot ram once to find its source and a free entry, then runs
// the 42 step serial divider for fraction lost when the source is found and
// the interval shows a loss above zero and smaller than the expected count;
// the first request of a report first works out the delay since the last
// sender report, by reciprocal multiplication. Results wait in an output
// register, so the next request is taken while a block is still waiting to
// be read; a request that finishes while the previous block is unread waits
// in its write stage.
// ----------------------------------------------------------------------------
module rtcp_report_block_generator
	import rtcp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// ntp time, time_ms, source_id, expected_count, received_count,
	// highest_sequence, jitter_value
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// operation, source_valid, first_of_report
	input  logic [IN_USER_W-1:0]  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// block_source, fraction lost, cumulative loss, block_highest_sequence,
	// block_jitter, last_sr, sr delay, block_position, zero fill
	output logic [OUT_DATA_W-1:0] m_tdata,
	// table_full
	output logic                  m_tuser,
	input  logic                  cfg_we,
	input  logic [0:0]            cfg_index,
	input  logic [CFG_W-1:0]      cfg_data
);

	state_t state_q, state_d;

	logic [15:0] interval_q;
	logic [4:0]  max_q;
	logic        seen_q;
	logic [63:0] arrival_q;
	logic [31:0] lsr_q, held_q, count_q;
	logic [5:0]  pos_q;
	logic [SNAP_ENTRIES-1:0] valid_q;

	logic [63:0] diff_q;
	logic        le_q;
	logic [31:0] src_q, exp_q, rec_q, hs_q, jit_q;
	logic        sv_q;

	logic [SNAP_AW:0]   scan_q;
	logic               chk_s1;
	logic [SNAP_AW-1:0] idx_s1;
	logic               hit_q, free_q;
	logic [SNAP_AW-1:0] hit_idx_q, free_idx_q;
	logic [31:0]        sexp_q, srec_q;
	logic [32:0]        eint_q;
	logic [33:0]        lost_q;
	logic [7:0]         frac_q;

	logic [18:0]        dly_a_s1;
	logic [6:0]         dly_b_s2;

	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic                  out_full_q;

	logic accept, scan_start, div_start;
	logic [DVD_W-1:0] div_dvd;
	logic [DSR_W-1:0] div_dsr;
	logic div_done;
	logic [DVD_W-1:0] div_quo;
	logic [SNAP_W-1:0] rd_data;
	logic ram_we;
	logic [SNAP_AW-1:0] wr_addr;
	logic [64:0] diff_w;
	logic scan_end, do_write;
	logic [32:0] cum_v;
	logic [23:0] cum_c;
	logic clr;
	logic [31:0] cnt_base;
	logic [32:0] eint_w, rint_w;
	logic [52:0] dly_prod_a;
	logic [25:0] dly_mul_w, dly_rem_w;
	logic [27:0] dly_prod_b;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_full_q;

	assign diff_w   = {1'b0, s_tdata[127:64]} - {1'b0, arrival_q};
	assign scan_end = (scan_q == (SNAP_AW+1)'(SNAP_ENTRIES)) && !chk_s1;
	assign do_write = (state_q == ST_WRITE) && (!out_valid_q || m_tready);
	assign ram_we   = do_write && (hit_q || free_q);
	assign wr_addr  = hit_q ? hit_idx_q : free_idx_q;

	// delay in 1/65536 s is diff * 8192 / 125, split as quotient and remainder by 125
	assign dly_prod_a = {27'd0, diff_q[25:0]} * {26'd0, DIV125_M};
	assign dly_mul_w  = {7'd0, dly_a_s1} * 26'd125;
	assign dly_rem_w  = diff_q[25:0] - dly_mul_w;
	assign dly_prod_b = {21'd0, dly_b_s2} * {7'd0, FRAC125_M};

	assign eint_w = {1'b0, exp_q} - {1'b0, sexp_q};
	assign rint_w = {1'b0, rec_q} - {1'b0, srec_q};

	assign cum_v = {1'b0, exp_q} - {1'b0, rec_q};
	always_comb begin
		if ($signed(cum_v) < -33'sd8388608) begin
			cum_c = 24'h800000;
		end else if ($signed(cum_v) > 33'sd8388607) begin
			cum_c = 24'h7FFFFF;
		end else begin
			cum_c = cum_v[23:0];
		end
	end

	assign clr      = (interval_q != 16'd0) && (count_q >= {16'd0, interval_q});
	assign cnt_base = clr ? 32'd0 : count_q;

	rtcp_ram #(
		.WIDTH(SNAP_W),
		.DEPTH(SNAP_ENTRIES)
	) u_snap (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wr_addr),
		.wdata({rec_q, exp_q, src_q}),
		.raddr(scan_q[SNAP_AW-1:0]),
		.rdata(rd_data)
	);

	rtcp_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dvd),
		.divisor (div_dsr),
		.done    (div_done),
		.quotient(div_quo)
	);

	always_comb begin
		state_d    = state_q;
		scan_start = 1'b0;
		div_start  = 1'b0;
		div_dvd    = {2'b00, lost_q[31:0], 8'd0};
		div_dsr    = eint_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && s_tuser[0] != OP_SENDER) begin
					if (s_tuser[2]) begin
						state_d = ST_DLY;
					end else if (s_tuser[1]) begin
						state_d    = ST_SCAN;
						scan_start = 1'b1;
					end
				end
			end
			ST_DLY: begin
				if (seen_q && arrival_q != 64'd0 && !le_q && diff_q < DELAY_SAT_MS) begin
					state_d = ST_DLYW;
				end else if (sv_q) begin
					state_d    = ST_SCAN;
					scan_start = 1'b1;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_DLYW: begin
				state_d = ST_DLYF;
			end
			ST_DLYF: begin
				if (sv_q) begin
					state_d    = ST_SCAN;
					scan_start = 1'b1;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_SCAN: begin
				if (scan_end) begin
					state_d = ST_FRAC1;
				end
			end
			ST_FRAC1: begin
				state_d = ST_FRAC2;
			end
			ST_FRAC2: begin
				if (!hit_q || eint_q[32] || eint_q == 33'd0 || lost_q[33] || lost_q == 34'd0
					|| $signed(lost_q) >= $signed({eint_q[32], eint_q})) begin
					state_d = ST_WRITE;
				end else begin
					div_start = 1'b1;
					state_d   = ST_FRACW;
				end
			end
			ST_FRACW: begin
				if (div_done) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				if (do_write) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q  <= 16'd0;
			max_q       <= 5'd31;
			seen_q      <= 1'b0;
			arrival_q   <= 64'd0;
			lsr_q       <= 32'd0;
			held_q      <= 32'd0;
			count_q     <= 32'd0;
			pos_q       <= 6'd0;
			valid_q     <= '0;
			scan_q      <= '0;
			chk_s1      <= 1'b0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_INTERVAL) begin
					interval_q <= cfg_data;
				end else begin
					max_q <= cfg_data[4:0];
				end
			end
			if (accept) begin
				if (s_tuser[0] == OP_SENDER) begin
					seen_q <= 1'b1;
					lsr_q  <= s_tdata[47:16];
					if (s_tdata[127:64] != 64'd0) begin
						arrival_q <= s_tdata[127:64];
					end
				end else if (s_tuser[2]) begin
					if (clr) begin
						valid_q <= '0;
					end
					if (interval_q != 16'd0) begin
						count_q <= (cnt_base == 32'hFFFFFFFF) ? cnt_base : cnt_base + 32'd1;
					end
					pos_q <= 6'd0;
				end
			end
			if (state_q == ST_DLY && state_d != ST_DLYW) begin
				if (seen_q && arrival_q != 64'd0 && !le_q) begin
					held_q <= 32'hFFFFFFFF;
				end else begin
					held_q <= 32'd0;
				end
			end
			if (state_q == ST_DLYF) begin
				held_q <= {dly_a_s1, dly_prod_b[26:14]};
			end
			if (scan_start) begin
				scan_q <= '0;
				chk_s1 <= 1'b0;
				hit_q  <= 1'b0;
				free_q <= 1'b0;
			end else if (state_q == ST_SCAN) begin
				chk_s1 <= (scan_q != (SNAP_AW+1)'(SNAP_ENTRIES));
				if (scan_q != (SNAP_AW+1)'(SNAP_ENTRIES)) begin
					scan_q <= scan_q + 1'b1;
				end
				if (chk_s1) begin
					if (valid_q[idx_s1] && rd_data[31:0] == src_q) begin
						hit_q <= 1'b1;
					end
					if (!valid_q[idx_s1] && !free_q) begin
						free_q <= 1'b1;
					end
				end
			end
			if (do_write && pos_q < {1'b0, max_q}) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (do_write) begin
				if (hit_q || free_q) begin
					valid_q[wr_addr] <= 1'b1;
				end
				if (pos_q != 6'd63) begin
					pos_q <= pos_q + 6'd1;
				end
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept) begin
			diff_q <= diff_w[63:0];
			le_q   <= diff_w[64] || (diff_w[63:0] == 64'd0);
			src_q  <= s_tdata[159:128];
			exp_q  <= s_tdata[191:160];
			rec_q  <= s_tdata[223:192];
			hs_q   <= s_tdata[255:224];
			jit_q  <= s_tdata[287:256];
			sv_q   <= s_tuser[1];
		end
		if (state_q == ST_DLY) begin
			dly_a_s1 <= dly_prod_a[51:33];
		end
		if (state_q == ST_DLYW) begin
			dly_b_s2 <= dly_rem_w[6:0];
		end
		idx_s1 <= scan_q[SNAP_AW-1:0];
		if (state_q == ST_SCAN && chk_s1) begin
			if (valid_q[idx_s1] && rd_data[31:0] == src_q) begin
				hit_idx_q <= idx_s1;
				sexp_q    <= rd_data[63:32];
				srec_q    <= rd_data[95:64];
			end
			if (!valid_q[idx_s1] && !free_q) begin
				free_idx_q <= idx_s1;
			end
		end
		if (state_q == ST_FRAC1) begin
			eint_q <= eint_w;
			lost_q <= {eint_w[32], eint_w} - {rint_w[32], rint_w};
		end
		if (state_q == ST_FRAC2) begin
			if (!hit_q || eint_q[32] || eint_q == 33'd0 || lost_q[33] || lost_q == 34'd0) begin
				frac_q <= 8'd0;
			end else begin
				frac_q <= 8'd255;
			end
		end
		if (state_q == ST_FRACW && div_done) begin
			frac_q <= div_quo[7:0];
		end
		if (do_write && pos_q < {1'b0, max_q}) begin
			out_data_q <= {3'd0, pos_q[4:0], held_q, lsr_q, jit_q, hs_q, cum_c, frac_q, src_q};
			out_full_q <= !(hit_q || free_q);
		end
	end

endmodule
